// ----- rtl/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// Types and codes shared by the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Handle layout
  localparam int GenW = 16;
  localparam int IdxFieldW = 16;
  localparam int PayW = 32;
  localparam logic [GenW-1:0] GenFirst = 16'd1;

  // Command beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] handle_in;
    logic [31:0] payload_in;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] payload_out;
  } rsp_t;

endpackage

// ----- rtl/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot table handing out generation:index handles; allocate, lookup, release.
// ----------------------------------------------------------------------------
//
//  channel  | ports             | handshake
//  ---------+-------------------+--------------------------------------------
//  command  | start, busy, req  | beat taken at edge with start & !busy
//  result   | done, rsp         | one-cycle strobe, no backpressure
//
//  For each command, the accept cycle issues the slot memory read,
//  the next cycle checks, writes back and registers the result. The result
//  shows in the following cycle, while busy is already low again.
//  After reset, busy stays high while a clearing pass writes generation 1
//  into every slot of the memory.
//  The receiver cannot stall; every result is shown exactly once.
//
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MemW = GenW + PayW;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  // Slot memory: {generation, payload}
  logic [MemW-1:0] mem [SLOT_COUNT];
  logic [MemW-1:0] mem_rdata;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [MemW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_raddr;

  logic [SLOT_COUNT-1:0] slot_busy;
  logic [IdxW-1:0]       clr_ptr;

  // Operation registers
  logic [1:0]      op_cmd;
  logic [IdxW-1:0] op_slot;
  logic            op_null;
  logic            op_full;
  logic [GenW-1:0] op_gen;
  logic [PayW-1:0] op_payload;

  // Request decode
  logic [IdxFieldW-1:0] in_idx;
  logic                 in_null;
  logic [IdxW-1:0]      in_slot;
  logic                 free_found;
  logic [IdxW-1:0]      free_idx;
  logic                 accept;

  rsp_t            rsp_next;
  logic [GenW-1:0] rd_gen;
  logic [GenW-1:0] gen_inc;
  logic            hit;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Decode the handle index field
  assign in_idx  = req.handle_in[IdxFieldW-1:0];
  assign in_null = (in_idx == '0) ||
                   ({1'b0, in_idx} > (IdxFieldW+1)'(SLOT_COUNT));
  assign in_slot = in_null ? '0 : IdxW'(in_idx - 16'd1);

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign mem_raddr = (req.cmd == CMD_ALLOC) ? free_idx : in_slot;

  // Memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Check, write back and form the result
  assign rd_gen  = mem_rdata[MemW-1:PayW];
  assign gen_inc = (rd_gen == 16'hFFFF) ? GenFirst : rd_gen + 16'd1;
  assign hit     = !op_null && (rd_gen == op_gen) && slot_busy[op_slot];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_slot;
    mem_wdata = '0;
    rsp_next  = '0;
    rsp_next.status = ST_NULL;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr;
      mem_wdata = {GenFirst, {PayW{1'b0}}};
    end else if (state == S_EXEC) begin
      unique case (op_cmd)
        CMD_ALLOC: begin
          if (op_full) begin
            rsp_next.status = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {rd_gen, op_payload};
            rsp_next.status     = ST_OK;
            rsp_next.handle_out = {rd_gen, IdxFieldW'(op_slot) + 16'd1};
          end
        end
        CMD_LOOKUP: begin
          if (op_null) begin
            rsp_next.status = ST_NULL;
          end else if (!hit) begin
            rsp_next.status = ST_STALE;
          end else begin
            rsp_next.status      = ST_OK;
            rsp_next.payload_out = mem_rdata[PayW-1:0];
          end
        end
        CMD_RELEASE: begin
          if (op_null) begin
            rsp_next.status = ST_NULL;
          end else if (!hit) begin
            rsp_next.status = ST_STALE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {gen_inc, {PayW{1'b0}}};
            rsp_next.status = ST_OK;
          end
        end
        default: begin
          rsp_next.status = ST_NULL;
        end
      endcase
    end
  end

  // Sequence: clear pass, idle, execute
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_ptr == LastSlot) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      slot_busy <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      // Track occupancy on successful allocate and release
      if (state == S_EXEC) begin
        if (op_cmd == CMD_ALLOC && !op_full) begin
          slot_busy[op_slot] <= 1'b1;
        end else if (op_cmd == CMD_RELEASE && hit) begin
          slot_busy[op_slot] <= 1'b0;
        end
      end
    end
  end

  // Hold the command beat for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd     <= req.cmd;
      op_slot    <= mem_raddr;
      op_null    <= in_null || (req.cmd != CMD_LOOKUP && req.cmd != CMD_RELEASE);
      op_full    <= !free_found;
      op_gen     <= req.handle_in[31:IdxFieldW];
      op_payload <= req.payload_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      rsp <= rsp_next;
    end
  end

endmodule
